>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by the channel interfaces, the storage, compare and control modules and the checker.
package spq_pkg;

   localparam int CAPACITY_DEFAULT     = 16;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   localparam int ACTION_W   = 3;
   localparam int PRIORITY_W = 16;
   localparam int PAYLOAD_W  = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_SORTED = 3'd0,
      ACT_INSERT_FRONT  = 3'd1,
      ACT_INSERT_BACK   = 3'd2,
      ACT_REMOVE        = 3'd3,
      ACT_PEEK_FRONT    = 3'd4,
      ACT_PEEK_BACK     = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic equal;
      logic follow;
   } cmp_result_type;

endpackage

>>> hdl/spq_if.sv
// Valid/ready channel interfaces for requests, responses and the control register write.
// Depends on spq_pkg for the field widths.
interface spq_req_if;
   import spq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [PRIORITY_W-1:0] priority_req;
   logic [PAYLOAD_W-1:0]  payload;
   modport source (output valid, output action, output priority_req, output payload,
                   input ready);
   modport sink (input valid, input action, input priority_req, input payload,
                 output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PAYLOAD_W-1:0]  out_payload;
   logic [PRIORITY_W-1:0] out_priority;
   logic [COUNT_W-1:0]    count;
   modport source (output valid, output status, output out_payload, output out_priority,
                   output count, input ready);
   modport sink (input valid, input status, input out_payload, input out_priority,
                 input count, output ready);
endinterface

interface spq_csr_if;
   logic valid;
   logic ready;
   logic descending_order;
   modport source (output valid, output descending_order, input ready);
   modport sink (input valid, input descending_order, output ready);
endinterface

>>> hdl/spq_ram.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on spq_pkg for default sizes.
module spq_ram #(
   parameter int  DEPTH  = spq_pkg::CAPACITY_DEFAULT,
   parameter int  WIDTH  = spq_pkg::PRIORITY_W + spq_pkg::PAYLOAD_BITS_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/spq_cmp.sv
// Shared priority comparator used for ordered placement and for matching on removal.
// Depends on spq_pkg for the priority width and the result struct.
module spq_cmp (
   input  logic [spq_pkg::PRIORITY_W-1:0] held_pri,
   input  logic [spq_pkg::PRIORITY_W-1:0] key_pri,
   input  logic                           descending,
   output spq_pkg::cmp_result_type        result
);
   import spq_pkg::*;

   always_comb begin
      result.equal  = (held_pri == key_pri);
      result.follow = descending ? (held_pri < key_pri) : (held_pri > key_pri);
   end
endmodule

>>> hdl/spq_ctrl.sv
// Sequencer that walks the entry storage one slot per cycle for inserts and removals.
// Depends on spq_pkg, spq_if, spq_ram and spq_cmp.
module spq_ctrl #(
   parameter int CAPACITY     = spq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      descending,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W = PRIORITY_W + PAYLOAD_BITS;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_INS, S_PUT, S_SRCH, S_SHIFT, S_PEEK, S_DONE
   } state_type;

   state_type                state_ff, state_in;
   action_type               act_ff, act_in;
   logic [PRIORITY_W-1:0]    pri_ff, pri_in;
   logic [PAYLOAD_BITS-1:0]  pay_ff, pay_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               res_status_ff, res_status_in;
   logic [PAYLOAD_BITS-1:0]  res_pay_ff, res_pay_in;
   logic [PRIORITY_W-1:0]    res_pri_ff, res_pri_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0]     rsp_pay_ff, rsp_pay_in;
   logic [PRIORITY_W-1:0]    rsp_pri_ff, rsp_pri_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [WORD_W-1:0]        ram_wdata;
   logic [IDX_W-1:0]         ram_raddr;
   logic [WORD_W-1:0]        ram_rdata;
   logic [PRIORITY_W-1:0]    rd_pri;
   logic [PAYLOAD_BITS-1:0]  rd_pay;
   cmp_result_type           cmp;
   logic [CNT_W-1:0]         idx_next;
   logic [CNT_W-1:0]         idx_prev;
   logic [CNT_W-1:0]         idx_prev2;
   logic [CNT_W-1:0]         count_last;
   logic                     at_last;
   logic                     rsp_free;

   spq_ram #(.DEPTH(CAPACITY), .WIDTH(WORD_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_pri = ram_rdata[WORD_W-1 -: PRIORITY_W];
   assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

   spq_cmp u_cmp (
      .held_pri   (rd_pri),
      .key_pri    (pri_ff),
      .descending (descending),
      .result     (cmp)
   );

   assign idx_next   = idx_ff + 1'b1;
   assign idx_prev   = idx_ff - 1'b1;
   assign idx_prev2  = idx_ff - 2'd2;
   assign count_last = count_ff - 1'b1;
   assign at_last    = (idx_next == count_ff);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      pri_in        = pri_ff;
      pay_in        = pay_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pay_in    = res_pay_ff;
      res_pri_in    = res_pri_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IDX_W-1:0];
      ram_wdata     = {pri_ff, pay_ff};
      ram_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               act_in   = action_type'(req.action);
               pri_in   = req.priority_req;
               pay_in   = PAYLOAD_BITS'(req.payload);
               state_in = S_START;
            end
         end
         S_START: begin
            res_status_in = STATUS_OK;
            res_pay_in    = '0;
            res_pri_in    = '0;
            state_in      = S_DONE;
            case (act_ff)
               ACT_INSERT_SORTED, ACT_INSERT_FRONT, ACT_INSERT_BACK: begin
                  if (count_ff == CAP_COUNT) begin
                     res_status_in = STATUS_FULL;
                  end else if (act_ff == ACT_INSERT_BACK || count_ff == '0) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[IDX_W-1:0];
                     count_in  = count_ff + 1'b1;
                  end else begin
                     ram_raddr = count_last[IDX_W-1:0];
                     idx_in    = count_ff;
                     state_in  = S_INS;
                  end
               end
               ACT_REMOVE: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_SRCH;
                  end
               end
               ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     ram_raddr = (act_ff == ACT_PEEK_FRONT) ? '0 : count_last[IDX_W-1:0];
                     state_in  = S_PEEK;
                  end
               end
               default: begin
                  res_status_in = STATUS_OK;
               end
            endcase
         end
         S_INS: begin
            if (act_ff == ACT_INSERT_FRONT || cmp.follow) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               idx_in    = idx_prev;
               if (idx_prev == '0) begin
                  state_in = S_PUT;
               end else begin
                  ram_raddr = idx_prev2[IDX_W-1:0];
               end
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            ram_we   = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_SRCH: begin
            if (cmp.equal) begin
               res_pay_in = rd_pay;
               res_pri_in = rd_pri;
               if (at_last) begin
                  count_in = count_last;
                  state_in = S_DONE;
               end else begin
                  ram_raddr = idx_next[IDX_W-1:0];
                  idx_in    = idx_next;
                  state_in  = S_SHIFT;
               end
            end else if (at_last) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               ram_raddr = idx_next[IDX_W-1:0];
               idx_in    = idx_next;
            end
         end
         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_prev[IDX_W-1:0];
            ram_wdata = ram_rdata;
            if (at_last) begin
               count_in = count_last;
               state_in = S_DONE;
            end else begin
               ram_raddr = idx_next[IDX_W-1:0];
               idx_in    = idx_next;
            end
         end
         S_PEEK: begin
            res_pay_in = rd_pay;
            res_pri_in = rd_pri;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pay_in    = PAYLOAD_W'(res_pay_ff);
               rsp_pri_in    = res_pri_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A remove walks the slots from the front, so its first read is slot zero.
      if (state_ff == S_START && act_ff == ACT_REMOVE) begin
         ram_raddr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      pri_ff        <= pri_in;
      pay_ff        <= pay_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_pay_ff    <= res_pay_in;
      res_pri_ff    <= res_pri_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_payload  = rsp_pay_ff;
   assign rsp.out_priority = rsp_pri_ff;
   assign rsp.count        = rsp_count_ff;
endmodule

>>> hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: top level with the order control register and the sequencer.
// Depends on spq_pkg, spq_if and spq_ctrl.
//
// Requests arrive on req (action, priority_req, payload) and each gives exactly one
// response on rsp (status, out_payload, out_priority, count). The csr channel writes
// the descending_order bit; it is always ready, and the user must write it only while
// the queue is idle; the block itself does not enforce this. Entries sit in a memory of
// CAPACITY slots with slot zero at the front. An insert or a removal walks the memory
// one slot per cycle through a single read and write port, shifting entries as it
// goes. Only one request is in work at a time; req.ready is high only while the
// sequencer is idle and rises together with the response, so the next request can be
// taken while that response is presented.
// The response sits in an output register. While the receiver stalls, a new request
// can already be taken, but a request that finishes while that register is still full
// waits in the sequencer with req.ready low. Reset empties the queue, clears a pending
// response and selects ascending order; the memory is not cleared.
module sorted_priority_queue_unit #(
   parameter int CAPACITY     = spq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp,
   spq_csr_if.sink   csr
);
   import spq_pkg::*;

   logic descending_ff, descending_in;

   always_comb begin
      descending_in = descending_ff;
      if (csr.valid) begin
         descending_in = csr.descending_order;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else begin
         descending_ff <= descending_in;
      end
   end

   assign csr.ready = 1'b1;

   spq_ctrl #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .descending (descending_ff),
      .req        (req),
      .rsp        (rsp)
   );
endmodule

>>> hdl/spq_checker.sv
// Port-level checks on the response channel of the sorted priority queue.
// Depends on spq_pkg; bound to sorted_priority_queue_unit at the end of this file.
module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [spq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [spq_pkg::PAYLOAD_W-1:0]  rsp_out_payload,
   input logic [spq_pkg::PRIORITY_W-1:0] rsp_out_priority,
   input logic [spq_pkg::COUNT_W-1:0]    rsp_count
);
   import spq_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_payload) && $stable(rsp_out_priority) && $stable(rsp_count))
      else $error("Stalled response changed before its transfer.");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_out_payload == '0 && rsp_out_priority == '0)
      else $error("Failed action returned entry data.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_count == '0)
      else $error("Empty status with a nonzero count.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == CAP_COUNT)
      else $error("Full status while the queue is not at capacity.");
endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_out_payload  (rsp.out_payload),
   .rsp_out_priority (rsp.out_priority),
   .rsp_count        (rsp.count)
);

>>> bench/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit, with its own queue predictor.
// Depends on spq_pkg and the channel interfaces in spq_if.
module tb_sorted_priority_queue_unit;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY_DEFAULT;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
   localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PAYLOAD_W-1:0]  payload;
      logic [PRIORITY_W-1:0] prio;
      logic [COUNT_W-1:0]    count;
   } queue_result;

   class queue_scoreboard;
      logic [PRIORITY_W-1:0] slot_prio [QUEUE_DEPTH];
      logic [PAYLOAD_W-1:0]  slot_data [QUEUE_DEPTH];
      int held;
      bit descending;
      queue_result awaited [$];
      int mismatches;

      function new();
         held = 0;
         descending = 1'b0;
         mismatches = 0;
      endfunction

      function bit must_trail(logic [PRIORITY_W-1:0] held_prio, logic [PRIORITY_W-1:0] prio);
         return descending ? (held_prio < prio) : (held_prio > prio);
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic [PRIORITY_W-1:0] prio,
                                 logic [PAYLOAD_W-1:0] data);
         queue_result res;
         int pos;
         int i;
         res = '0;
         case (act)
            ACT_INSERT_SORTED, ACT_INSERT_FRONT, ACT_INSERT_BACK: begin
               if (held >= QUEUE_DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  if (act == ACT_INSERT_FRONT) begin
                     pos = 0;
                  end else begin
                     pos = held;
                     if (act == ACT_INSERT_SORTED) begin
                        while (pos > 0 && must_trail(slot_prio[pos-1], prio)) pos--;
                     end
                  end
                  for (i = held; i > pos; i--) begin
                     slot_prio[i] = slot_prio[i-1];
                     slot_data[i] = slot_data[i-1];
                  end
                  slot_prio[pos] = prio;
                  slot_data[pos] = data;
                  held++;
               end
            end
            ACT_REMOVE, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
               if (held == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (act == ACT_REMOVE) begin
                  pos = 0;
                  while (pos < held && slot_prio[pos] != prio) pos++;
                  if (pos >= held) begin
                     res.status = STATUS_NOT_FOUND;
                  end else begin
                     res.payload = slot_data[pos];
                     res.prio = slot_prio[pos];
                     for (i = pos; i + 1 < held; i++) begin
                        slot_prio[i] = slot_prio[i+1];
                        slot_data[i] = slot_data[i+1];
                     end
                     held--;
                  end
               end else begin
                  pos = (act == ACT_PEEK_FRONT) ? 0 : held - 1;
                  res.payload = slot_data[pos];
                  res.prio = slot_prio[pos];
               end
            end
            default: ;
         endcase
         res.count = held[COUNT_W-1:0];
         awaited.push_back(res);
      endfunction

      function void check_response(queue_result got);
         queue_result want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response status=%0d payload=%h prio=%h count=%0d",
                        $realtime, got.status, got.payload, got.prio, got.count);
         end else begin
            want = awaited.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch expected status=%0d payload=%h prio=%h count=%0d",
                            " actual status=%0d payload=%h prio=%h count=%0d"},
                           $realtime, want.status, want.payload, want.prio, want.count,
                           got.status, got.payload, got.prio, got.count);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit quiet;
   queue_scoreboard sb;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();
   spq_csr_if csr_ch ();

   sorted_priority_queue_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      queue_result got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got.status = rsp_ch.status;
         got.payload = rsp_ch.out_payload;
         got.prio = rsp_ch.out_priority;
         got.count = rsp_ch.count;
         sb.check_response(got);
      end
   end

   task automatic send(input logic [ACTION_W-1:0] act, input logic [PRIORITY_W-1:0] prio,
                       input logic [PAYLOAD_W-1:0] data);
      req_ch.valid = 1'b1;
      req_ch.action = act;
      req_ch.priority_req = prio;
      req_ch.payload = data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(act, prio, data);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   task automatic write_order(input logic descending);
      csr_ch.valid = 1'b1;
      csr_ch.descending_order = descending;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.descending = descending;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [PRIORITY_W-1:0] pick_prio();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5, 6: return PRIORITY_W'($urandom_range(0, 11));
         default: return PRIORITY_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int phase;
      int done;
      int roll;
      bit grow;
      logic [ACTION_W-1:0] act;
      logic [PRIORITY_W-1:0] prio;

      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_INSERT_SORTED;
      req_ch.priority_req = '0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.descending_order = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Ascending order: empty queue cases, extremes, ties and every action.
      write_order(1'b0);
      send(ACT_PEEK_FRONT, 16'h0000, 32'h0);
      send(ACT_PEEK_BACK, 16'h0000, 32'h0);
      send(ACT_REMOVE, 16'h0000, 32'h0);
      send(ACT_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF);
      send(ACT_SPARE_B, 16'h5A5A, 32'hA5A5_A5A5);
      send(ACT_INSERT_SORTED, 16'h8000, 32'h0000_0000);
      send(ACT_INSERT_SORTED, 16'hFFFF, 32'hFFFF_FFFF);
      send(ACT_INSERT_SORTED, 16'h0000, 32'h0000_0001);
      send(ACT_INSERT_SORTED, 16'h8000, 32'h0000_0002);
      send(ACT_INSERT_FRONT, 16'h1234, 32'h1234_5678);
      send(ACT_INSERT_BACK, 16'h0001, 32'h8765_4321);
      send(ACT_PEEK_FRONT, 16'h0000, 32'h0);
      send(ACT_PEEK_BACK, 16'h0000, 32'h0);
      send(ACT_REMOVE, 16'h7777, 32'h0);
      send(ACT_REMOVE, 16'h8000, 32'h0);
      send(ACT_REMOVE, 16'h1234, 32'h0);
      drain();

      // Descending order on top of what is still held.
      write_order(1'b1);
      send(ACT_INSERT_SORTED, 16'h0005, 32'hCAFE_0001);
      send(ACT_INSERT_SORTED, 16'h0009, 32'hCAFE_0002);
      send(ACT_INSERT_SORTED, 16'h0005, 32'hCAFE_0003);
      send(ACT_INSERT_SORTED, 16'hFFFF, 32'hCAFE_0004);
      send(ACT_PEEK_FRONT, 16'h0000, 32'h0);
      send(ACT_REMOVE, 16'h0005, 32'h0);

      // Random phases alternate between filling and emptying the queue so that the
      // full and empty cases both recur. The last phase runs without idling.
      for (phase = 0; phase < 4; phase++) begin
         drain();
         quiet = (phase == 3);
         write_order(phase[0]);
         done = 0;
         grow = 1'b1;
         while (done < 195) begin
            if (done % 30 == 29) grow = !grow;
            roll = $urandom_range(0, 99);
            if (grow) begin
               if (roll < 40) act = ACT_INSERT_SORTED;
               else if (roll < 55) act = ACT_INSERT_FRONT;
               else if (roll < 70) act = ACT_INSERT_BACK;
               else if (roll < 82) act = ACT_REMOVE;
               else if (roll < 89) act = ACT_PEEK_FRONT;
               else if (roll < 96) act = ACT_PEEK_BACK;
               else act = (roll < 98) ? ACT_SPARE_A : ACT_SPARE_B;
            end else begin
               if (roll < 15) act = ACT_INSERT_SORTED;
               else if (roll < 20) act = ACT_INSERT_FRONT;
               else if (roll < 25) act = ACT_INSERT_BACK;
               else if (roll < 75) act = ACT_REMOVE;
               else if (roll < 85) act = ACT_PEEK_FRONT;
               else if (roll < 96) act = ACT_PEEK_BACK;
               else act = (roll < 98) ? ACT_SPARE_A : ACT_SPARE_B;
            end
            if (act == ACT_REMOVE && sb.held > 0 && $urandom_range(0, 9) < 7)
               prio = sb.slot_prio[$urandom_range(0, sb.held - 1)];
            else
               prio = pick_prio();
            send(act, prio, $urandom);
            if (act != ACT_SPARE_A && act != ACT_SPARE_B) done++;
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
